/* src/crpu_pkg.sv */
// Types and constants shared by the counter request priority unit.
package crpu_pkg;

	// Width of a counter cell index and of the read bus address
	localparam int IDX_W  = 3;
	localparam int ADDR_W = 6;

	// Index reported when no latched cell is active
	localparam logic [IDX_W-1:0] NONE_SELECTED = 3'd7;
	// Read bus address of counter cell zero (octal 34)
	localparam logic [ADDR_W-1:0] BASE_ADDRESS = 6'o34;

	// Counter cell layout
	localparam logic [IDX_W-1:0] CELL_OVCTR = 3'd0;
	localparam logic [IDX_W-1:0] CELL_TIME2 = 3'd1;
	localparam logic [IDX_W-1:0] CELL_TIME1 = 3'd2;
	localparam logic [IDX_W-1:0] CELL_TIME3 = 3'd3;
	localparam logic [IDX_W-1:0] CELL_TIME4 = 3'd4;

	// Item kinds
	typedef enum logic [2:0] {
		KIND_RESET   = 3'd0,
		KIND_LATCH   = 3'd1,
		KIND_QUERY   = 3'd2,
		KIND_DONE    = 3'd3,
		KIND_OVCOUNT = 3'd4,
		KIND_REQUEST = 3'd5
	} kind_t;

	// Write bus overflow codes
	localparam logic [1:0] OVF_NONE = 2'd0;
	localparam logic [1:0] OVF_POS  = 2'd1;
	localparam logic [1:0] OVF_NEG  = 2'd2;

	// Subsequence codes
	localparam logic [1:0] SUB_NONE  = 2'd0;
	localparam logic [1:0] SUB_PLUS  = 2'd1;
	localparam logic [1:0] SUB_MINUS = 2'd2;

	// Input beat
	typedef struct packed {
		logic [2:0]       kind;
		logic [1:0]       overflow;
		logic [IDX_W-1:0] request_index;
		logic             request_down;
	} in_t;

	// Result beat
	typedef struct packed {
		logic [IDX_W-1:0]  selected_index;
		logic [ADDR_W-1:0] counter_address;
		logic [1:0]        subsequence;
		logic              timer3_interrupt;
		logic              downlink_interrupt;
	} out_t;

endpackage

/* src/crpu_sel.sv */
// Priority encoder over the latched counter cells, with subsequence decode.
module crpu_sel #(
	parameter int NUM_COUNTERS = 8
) (
	input  logic [NUM_COUNTERS-1:0] lat_up,
	input  logic [NUM_COUNTERS-1:0] lat_dn,
	output logic [crpu_pkg::IDX_W-1:0] sel,
	output logic [NUM_COUNTERS-1:0] hit,
	output logic [1:0]              sub
);
	import crpu_pkg::*;

	logic [NUM_COUNTERS-1:0] active;
	logic                    up;
	logic                    dn;

	assign active = lat_up | lat_dn;

	// Pick the lowest-numbered active cell, defaulting to the idle index
	always_comb begin
		sel = NONE_SELECTED;
		for (int i = NUM_COUNTERS - 1; i >= 0; i--) begin
			if (active[i]) begin
				sel = IDX_W'(i);
			end
		end
	end

	// One-hot mask of the selected cell, empty when it lies beyond the array
	always_comb begin
		for (int i = 0; i < NUM_COUNTERS; i++) begin
			hit[i] = (sel == IDX_W'(i));
		end
	end

	// Decode direction; both or neither set means no subsequence
	assign up = |(lat_up & hit);
	assign dn = |(lat_dn & hit);

	always_comb begin
		if (up && !dn) begin
			sub = SUB_PLUS;
		end else if (!up && dn) begin
			sub = SUB_MINUS;
		end else begin
			sub = SUB_NONE;
		end
	end

endmodule

/* src/crpu_state.sv */
// Pending and latched flag registers with their per-beat update and result.
module crpu_state #(
	parameter int NUM_COUNTERS = 8
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  crpu_pkg::in_t  item,
	output crpu_pkg::out_t result
);
	import crpu_pkg::*;

	localparam logic [NUM_COUNTERS-1:0] OVCTR_BIT = NUM_COUNTERS'(1) << CELL_OVCTR;
	localparam logic [NUM_COUNTERS-1:0] TIME2_BIT = NUM_COUNTERS'(1) << CELL_TIME2;

	logic [NUM_COUNTERS-1:0] pend_up_q, pend_dn_q, lat_up_q, lat_dn_q;
	logic [NUM_COUNTERS-1:0] pend_up_n, pend_dn_n, lat_up_n, lat_dn_n;
	logic [NUM_COUNTERS-1:0] hit_c, hit_n, req_bit;
	logic [IDX_W-1:0]        sel_c, sel_n;
	logic [1:0]              sub_c, sub_n;
	logic                    t3, t4;

	// Selection on the flags as they stand, used by counter done
	crpu_sel #(.NUM_COUNTERS(NUM_COUNTERS)) u_sel_cur (
		.lat_up(lat_up_q),
		.lat_dn(lat_dn_q),
		.sel   (sel_c),
		.hit   (hit_c),
		.sub   (sub_c)
	);

	// Selection after this beat's update, reported in the result
	crpu_sel #(.NUM_COUNTERS(NUM_COUNTERS)) u_sel_nxt (
		.lat_up(lat_up_n),
		.lat_dn(lat_dn_n),
		.sel   (sel_n),
		.hit   (hit_n),
		.sub   (sub_n)
	);

	// Decode the requested cell; out-of-range indexes match nothing
	always_comb begin
		for (int i = 0; i < NUM_COUNTERS; i++) begin
			req_bit[i] = (item.request_index == IDX_W'(i));
		end
	end

	// Work out the next flag state for this beat
	always_comb begin
		pend_up_n = pend_up_q;
		pend_dn_n = pend_dn_q;
		lat_up_n  = lat_up_q;
		lat_dn_n  = lat_dn_q;
		t3        = 1'b0;
		t4        = 1'b0;
		case (item.kind)
			KIND_RESET: begin
				pend_up_n = '0;
				pend_dn_n = '0;
				lat_up_n  = '0;
				lat_dn_n  = '0;
			end
			KIND_LATCH: begin
				lat_up_n = pend_up_q;
				lat_dn_n = pend_dn_q;
			end
			KIND_DONE: begin
				if (|(lat_up_q & hit_c)) begin
					pend_up_n = pend_up_q & ~hit_c;
				end
				if (|(lat_dn_q & hit_c)) begin
					pend_dn_n = pend_dn_q & ~hit_c;
				end
				if (item.overflow == OVF_POS && (|hit_c)) begin
					if (sel_c == CELL_TIME1) begin
						pend_up_n = pend_up_n | TIME2_BIT;
					end else if (sel_c == CELL_TIME3) begin
						t3 = 1'b1;
					end else if (sel_c == CELL_TIME4) begin
						t4 = 1'b1;
					end
				end
			end
			KIND_OVCOUNT: begin
				if (item.overflow == OVF_POS) begin
					pend_up_n = pend_up_q | OVCTR_BIT;
				end else if (item.overflow == OVF_NEG) begin
					pend_dn_n = pend_dn_q | OVCTR_BIT;
				end
			end
			KIND_REQUEST: begin
				if (item.request_down) begin
					pend_dn_n = pend_dn_q | req_bit;
				end else begin
					pend_up_n = pend_up_q | req_bit;
				end
			end
			default: begin
			end
		endcase
	end

	// Commit the update when the beat moves on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_up_q <= '0;
			pend_dn_q <= '0;
			lat_up_q  <= '0;
			lat_dn_q  <= '0;
		end else if (en) begin
			pend_up_q <= pend_up_n;
			pend_dn_q <= pend_dn_n;
			lat_up_q  <= lat_up_n;
			lat_dn_q  <= lat_dn_n;
		end
	end

	// Assemble the result beat
	always_comb begin
		result.selected_index     = sel_n;
		result.counter_address    = BASE_ADDRESS + {{(ADDR_W-IDX_W){1'b0}}, sel_n};
		result.subsequence        = sub_n;
		result.timer3_interrupt   = t3;
		result.downlink_interrupt = t4;
	end

endmodule

/* src/counter_request_priority_unit_core.sv */
// Top level of the counter request priority unit: input and result registers.
//
// Usage:
//   The req channel carries one command beat (reset, latch, query, counter
//   done, overflow count, request); the rsp channel returns exactly one
//   result beat per command, in order. Both channels move a beat on a rising
//   edge with valid high and stall low.
//   An accepted beat goes into the input register, then through the flag
//   update and priority encode into the result register.
//   Throughput: one beat per cycle while rsp is not stalled, set by the
//   single flag update path; the input register refills while a finished
//   result waits in the output register.
//   When rsp is stalled the result register holds, the input register holds
//   its beat, and req_stall rises once both are full.
//   Reset (arst_n low) clears all pending and latched flags and empties both
//   registers; a general reset command does the same to the flags in band.
module counter_request_priority_unit_core #(
	parameter int NUM_COUNTERS = 8
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  crpu_pkg::in_t  req_data,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output crpu_pkg::out_t rsp_data
);
	import crpu_pkg::*;

	in_t  item_s1;
	logic valid_s1;
	out_t result;
	out_t rsp_q;
	logic rsp_valid_q;
	logic advance;

	// Move the held beat on when the result register is free or draining
	assign advance   = valid_s1 && (!rsp_valid_q || !rsp_stall);
	assign req_stall = valid_s1 && !advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!req_stall) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!req_stall && req_valid) begin
			item_s1 <= req_data;
		end
	end

	crpu_state #(.NUM_COUNTERS(NUM_COUNTERS)) u_state (
		.clk   (clk),
		.arst_n(arst_n),
		.en    (advance),
		.item  (item_s1),
		.result(result)
	);

	// Result register: load on advance, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_q <= result;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

	// Stall only ever holds a beat that is actually present
	a_stall_has_beat: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> valid_s1)
		else $error("req_stall raised with an empty input register");

	// A beat that advances always reaches the result register
	a_advance_fills: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> rsp_valid)
		else $error("advanced beat did not produce a result");

	// Timer interrupts only with the matching cell selected
	a_t3_cell: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_data.timer3_interrupt) |->
		(rsp_data.selected_index == CELL_TIME3 && !rsp_data.downlink_interrupt))
		else $error("timer3 interrupt without TIME3 selected");

	a_t4_cell: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_data.downlink_interrupt) |->
		(rsp_data.selected_index == CELL_TIME4))
		else $error("downlink interrupt without TIME4 selected");

endmodule

/* tb/tb_counter_request_priority_unit_core.sv */
// Self-checking testbench for the counter request priority unit core.
`timescale 1ns / 1ps

module tb_counter_request_priority_unit_core;
	import crpu_pkg::*;

	localparam int NUM_CELLS    = 8;
	localparam int RANDOM_BEATS = 1250;
	localparam int LIMIT_CYCLES = 400000;
	localparam int REPORT_MAX   = 10;

	// Kind codes outside the defined set, and the unused overflow code
	localparam logic [2:0] KIND_SPARE6  = 3'd6;
	localparam logic [2:0] KIND_SPARE7  = 3'd7;
	localparam logic [1:0] OVF_RESERVED = 2'd3;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	in_t  req_data  = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	out_t rsp_data;

	// Request from the sender for one long receiver hold-off
	bit long_hold_req = 1'b0;
	int beats_sent    = 0;
	int burst_left    = 0;
	int cycle_count   = 0;

	// Predicts the selection results and checks them in order
	class selection_scoreboard;
		logic [NUM_CELLS-1:0] pend_up, pend_dn, lat_up, lat_dn;
		out_t expected_selections[$];
		int unsigned failures;

		function new();
			pend_up  = '0;
			pend_dn  = '0;
			lat_up   = '0;
			lat_dn   = '0;
			failures = 0;
		endfunction

		function logic [NUM_CELLS-1:0] cell_mask(logic [IDX_W-1:0] idx);
			logic [NUM_CELLS-1:0] m;
			m = '0;
			if (idx < NUM_CELLS)
				m[idx] = 1'b1;
			return m;
		endfunction

		// Lowest-numbered latched cell, or the idle index
		function logic [IDX_W-1:0] pick_cell();
			logic [NUM_CELLS-1:0] active;
			active = lat_up | lat_dn;
			for (int i = 0; i < NUM_CELLS; i++)
				if (active[i])
					return IDX_W'(i);
			return NONE_SELECTED;
		endfunction

		// Apply an accepted beat and queue the selection it leaves behind
		function void note_beat(in_t b);
			logic [IDX_W-1:0]     sel;
			logic [NUM_CELLS-1:0] m;
			logic                 up, dn, t3, t4;
			out_t                 r;
			t3 = 1'b0;
			t4 = 1'b0;
			case (b.kind)
				KIND_RESET: begin
					pend_up = '0;
					pend_dn = '0;
					lat_up  = '0;
					lat_dn  = '0;
				end
				KIND_LATCH: begin
					lat_up = pend_up;
					lat_dn = pend_dn;
				end
				KIND_DONE: begin
					sel = pick_cell();
					m   = cell_mask(sel);
					pend_up &= ~(lat_up & m);
					pend_dn &= ~(lat_dn & m);
					if (b.overflow == OVF_POS && m != '0) begin
						if (sel == CELL_TIME1)
							pend_up |= cell_mask(CELL_TIME2);
						else if (sel == CELL_TIME3)
							t3 = 1'b1;
						else if (sel == CELL_TIME4)
							t4 = 1'b1;
					end
				end
				KIND_OVCOUNT: begin
					if (b.overflow == OVF_POS)
						pend_up |= cell_mask(CELL_OVCTR);
					else if (b.overflow == OVF_NEG)
						pend_dn |= cell_mask(CELL_OVCTR);
				end
				KIND_REQUEST: begin
					if (b.request_down)
						pend_dn |= cell_mask(b.request_index);
					else
						pend_up |= cell_mask(b.request_index);
				end
				default: ;
			endcase

			sel = pick_cell();
			m   = cell_mask(sel);
			up  = |(lat_up & m);
			dn  = |(lat_dn & m);
			r.selected_index     = sel;
			r.counter_address    = BASE_ADDRESS + ADDR_W'(sel);
			r.subsequence        = (up && !dn) ? SUB_PLUS : ((!up && dn) ? SUB_MINUS : SUB_NONE);
			r.timer3_interrupt   = t3;
			r.downlink_interrupt = t4;
			expected_selections.push_back(r);
		endfunction

		// Compare a result beat with the oldest prediction
		function void check_result(out_t got);
			out_t exp_r;
			bit   bad;
			if (expected_selections.size() == 0) begin
				failures++;
				if (failures <= REPORT_MAX)
					$display("ERROR: result beat with nothing pending: %p", got);
				return;
			end
			exp_r = expected_selections.pop_front();
			bad = (got.selected_index !== exp_r.selected_index) ||
				(got.counter_address !== exp_r.counter_address) ||
				(got.subsequence !== exp_r.subsequence) ||
				(got.timer3_interrupt !== exp_r.timer3_interrupt) ||
				(got.downlink_interrupt !== exp_r.downlink_interrupt);
			if (bad) begin
				failures++;
				if (failures <= REPORT_MAX)
					$display("ERROR: sel %0d/%0d addr %0o/%0o sub %0d/%0d t3 %0b/%0b dl %0b/%0b (exp/act)",
						exp_r.selected_index, got.selected_index,
						exp_r.counter_address, got.counter_address,
						exp_r.subsequence, got.subsequence,
						exp_r.timer3_interrupt, got.timer3_interrupt,
						exp_r.downlink_interrupt, got.downlink_interrupt);
			end
		endfunction
	endclass

	selection_scoreboard sb = new();

	counter_request_priority_unit_core #(
		.NUM_COUNTERS(NUM_CELLS)
	) uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_data  (req_data),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_data  (rsp_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == LIMIT_CYCLES) begin
			$display("counter_request_priority_unit_core verification failed");
			$finish;
		end
	end

	// Check every result beat taken by the receiver
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall)
			sb.check_result(rsp_data);
	end

	// Receiver: random stall segments, plus one long hold-off on request
	initial begin
		int seg_left;
		int pct;
		seg_left = 0;
		pct      = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				pct      = 100;
				seg_left = 150;
			end else if (seg_left == 0) begin
				case ($urandom_range(0, 4))
					0, 1: pct = 0;
					2: pct = 20;
					3: pct = 50;
					default: pct = 85;
				endcase
				seg_left = $urandom_range(5, 60);
			end
			seg_left--;
			rsp_stall <= ($urandom_range(0, 99) < pct);
		end
	end

	function automatic in_t make_beat(logic [2:0] kind, logic [1:0] ovf,
			logic [IDX_W-1:0] idx, logic dn);
		in_t b;
		b.kind          = kind;
		b.overflow      = ovf;
		b.request_index = idx;
		b.request_down  = dn;
		return b;
	endfunction

	// Random filler for the fields a kind does not use
	function automatic in_t rand_beat(logic [2:0] kind);
		return make_beat(kind, 2'($urandom_range(0, 3)), IDX_W'($urandom_range(0, 7)),
			1'($urandom_range(0, 1)));
	endfunction

	// Overflow code on counter done, weighted towards positive
	function automatic logic [1:0] done_overflow();
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: return OVF_POS;
			5, 6: return OVF_NEG;
			7, 8: return OVF_NONE;
			default: return OVF_RESERVED;
		endcase
	endfunction

	// Present one beat from a falling edge and hold it until accepted
	task automatic send_beat(input in_t b);
		req_data  <= b;
		req_valid <= 1'b1;
		do
			@(posedge clk);
		while (req_stall);
		sb.note_beat(b);
		beats_sent++;
		@(negedge clk);
	endtask

	// Send within bursts, idling for a random gap between them
	task automatic offer_beat(input in_t b);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 8);
			if (gap > 0) begin
				req_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 80)
				: $urandom_range(1, 16);
		end
		send_beat(b);
		burst_left--;
	endtask

	// Hold the sender until every predicted result has come back
	task automatic drain();
		req_valid <= 1'b0;
		burst_left = 0;
		while (sb.expected_selections.size() != 0)
			@(negedge clk);
	endtask

	// One command sequence: mostly request, latch, done chains
	task automatic run_sequence();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 3) begin
			offer_beat(rand_beat(KIND_RESET));
		end else if (pick < 15) begin
			repeat ($urandom_range(1, 6))
				offer_beat(rand_beat(3'($urandom_range(1, 7))));
		end else begin
			repeat ($urandom_range(1, 5))
				offer_beat(rand_beat(KIND_REQUEST));
			if ($urandom_range(0, 2) == 0)
				offer_beat(rand_beat(KIND_OVCOUNT));
			offer_beat(rand_beat(KIND_LATCH));
			repeat ($urandom_range(1, 6)) begin
				offer_beat(make_beat(KIND_DONE, done_overflow(),
					IDX_W'($urandom_range(0, 7)), 1'($urandom_range(0, 1))));
				if ($urandom_range(0, 4) != 0)
					offer_beat(rand_beat(KIND_LATCH));
				else if ($urandom_range(0, 1) == 0)
					offer_beat(rand_beat(KIND_QUERY));
			end
		end
	endtask

	initial begin
		in_t directed[$];
		bit  hold_done;
		bit  pause_done;
		hold_done  = 1'b0;
		pause_done = 1'b0;

		// Empty unit, then flags on both ends of the index range and a cell with both
		directed.push_back(make_beat(KIND_QUERY, OVF_NONE, 3'd0, 1'b0));
		directed.push_back(make_beat(KIND_LATCH, OVF_NONE, 3'd0, 1'b0));
		directed.push_back(make_beat(KIND_DONE, OVF_POS, 3'd7, 1'b1));
		directed.push_back(make_beat(KIND_REQUEST, OVF_RESERVED, CELL_OVCTR, 1'b0));
		directed.push_back(make_beat(KIND_REQUEST, OVF_NONE, 3'd7, 1'b1));
		directed.push_back(make_beat(KIND_REQUEST, OVF_NONE, CELL_TIME3, 1'b0));
		directed.push_back(make_beat(KIND_REQUEST, OVF_NEG, CELL_TIME3, 1'b1));
		directed.push_back(make_beat(KIND_REQUEST, OVF_NONE, CELL_TIME1, 1'b0));
		directed.push_back(make_beat(KIND_REQUEST, OVF_POS, CELL_TIME4, 1'b0));
		directed.push_back(make_beat(KIND_OVCOUNT, OVF_POS, 3'd0, 1'b0));
		directed.push_back(make_beat(KIND_OVCOUNT, OVF_NEG, 3'd7, 1'b1));
		directed.push_back(make_beat(KIND_LATCH, OVF_NONE, 3'd0, 1'b0));
		directed.push_back(make_beat(KIND_SPARE6, OVF_POS, 3'd0, 1'b0));
		// Walk the cells: OVCTR both ways, TIME1 chains TIME2, both TIME interrupts
		directed.push_back(make_beat(KIND_DONE, OVF_NEG, 3'd0, 1'b0));
		directed.push_back(make_beat(KIND_LATCH, OVF_NONE, 3'd0, 1'b0));
		directed.push_back(make_beat(KIND_DONE, OVF_POS, 3'd0, 1'b0));
		directed.push_back(make_beat(KIND_LATCH, OVF_NONE, 3'd0, 1'b0));
		directed.push_back(make_beat(KIND_DONE, OVF_POS, 3'd0, 1'b0));
		directed.push_back(make_beat(KIND_LATCH, OVF_NONE, 3'd0, 1'b0));
		directed.push_back(make_beat(KIND_DONE, OVF_POS, 3'd0, 1'b0));
		directed.push_back(make_beat(KIND_LATCH, OVF_NONE, 3'd0, 1'b0));
		directed.push_back(make_beat(KIND_DONE, OVF_POS, 3'd0, 1'b0));
		directed.push_back(make_beat(KIND_LATCH, OVF_NONE, 3'd0, 1'b0));
		directed.push_back(make_beat(KIND_DONE, OVF_RESERVED, 3'd0, 1'b0));
		directed.push_back(make_beat(KIND_SPARE7, OVF_NEG, 3'd7, 1'b1));
		directed.push_back(make_beat(KIND_RESET, OVF_NONE, 3'd0, 1'b0));

		// Hold reset, release on a falling edge
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (directed[i])
			send_beat(directed[i]);
		drain();

		beats_sent = 0;
		while (beats_sent < RANDOM_BEATS) begin
			run_sequence();
			// Long receiver hold-off with the sender still pushing
			if (!hold_done && beats_sent > RANDOM_BEATS / 3) begin
				hold_done     = 1'b1;
				long_hold_req = 1'b1;
				repeat (30)
					send_beat(rand_beat(3'($urandom_range(1, 5))));
			end
			// Pause the sender until all results are back
			if (!pause_done && beats_sent > (2 * RANDOM_BEATS) / 3) begin
				pause_done = 1'b1;
				drain();
			end
		end

		drain();
		repeat (8) @(posedge clk);
		if (sb.failures == 0 && sb.expected_selections.size() == 0)
			$display("counter_request_priority_unit_core verification clean");
		else
			$display("counter_request_priority_unit_core verification failed");
		$finish;
	end

endmodule

/* sim.f */
src/crpu_pkg.sv
src/crpu_sel.sv
src/crpu_state.sv
src/counter_request_priority_unit_core.sv
tb/tb_counter_request_priority_unit_core.sv
